// ===== rtl/dense_layer_forward_backward_sgd_core_defines.svh =====
// Assertion macros for the checker file of the dense layer core.
`ifndef DENSE_LAYER_FORWARD_BACKWARD_SGD_CORE_DEFINES_SVH
`define DENSE_LAYER_FORWARD_BACKWARD_SGD_CORE_DEFINES_SVH

// Same-cycle implication on the core clock, muted during reset.
`define DLFB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlfb check failed");

// Next-cycle implication on the core clock, muted during reset.
`define DLFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlfb check failed");

`endif

// ===== rtl/dlfb_pkg.sv =====
// Types, codes and constants shared by the dense layer core.
package dlfb_pkg;

   localparam int IDX_WIDTH  = 6;
   localparam int SIZE_WIDTH = 7;
   localparam int LR_WIDTH   = 16;
   localparam int VAL_WIDTH  = 32;
   localparam int FRAC_BITS  = 16;

   // request codes
   localparam logic [2:0] REQ_LOAD_W = 3'd0;
   localparam logic [2:0] REQ_LOAD_B = 3'd1;
   localparam logic [2:0] REQ_FWD    = 3'd2;
   localparam logic [2:0] REQ_ERR    = 3'd3;
   localparam logic [2:0] REQ_READ_W = 3'd4;
   localparam logic [2:0] REQ_READ_B = 3'd5;

   // result kinds
   localparam logic [1:0] OUT_FWD  = 2'd0;
   localparam logic [1:0] OUT_ERR  = 2'd1;
   localparam logic [1:0] OUT_READ = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_INPUTS  = 2'd0;
   localparam logic [1:0] CSR_OUTPUTS = 2'd1;
   localparam logic [1:0] CSR_LRATE   = 2'd2;

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] value;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         out_kind;
      logic [5:0]         out_index;
      logic signed [31:0] out_value;
      logic               out_last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      K_FWD, K_ERR, K_UPD, K_BUPD, K_RDW, K_RDB
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_FWD, ST_ERR, ST_UPD, ST_BUPD, ST_DRAIN
   } state_type;

   // run or read launch from the request decoder
   typedef struct packed {
      logic                 go;
      kind_type             op;
      logic [IDX_WIDTH-1:0] ri;
      logic [IDX_WIDTH-1:0] ci;
   } launch_type;

   // one memory access issued by the sequencer
   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [IDX_WIDTH-1:0] ri;
      logic [IDX_WIDTH-1:0] ci;
      logic                 first;
      logic                 gend;
      logic                 rend;
   } cmd_type;

endpackage

// ===== rtl/dense_layer_forward_backward_sgd_core.sv =====
// Top level of the dense layer core: request decode, stores and MAC pipeline.
//
//   channel | ports                        | handshake
//   --------+------------------------------+-----------------------------
//   request | start, busy, req_item        | taken when start && !busy
//   result  | rsp_valid, rsp_item          | one cycle strobe, no stall
//   config  | csr_valid, csr_ready, csr_*  | written when valid && ready
//
// Loads and element writes complete at the accepting edge. A read keeps the core busy until it drains.
// A forward run walks all N*M weights, an error run walks them twice and then the M biases:
// one multiply-accumulate per cycle through the single weight memory port.
// Reset is synchronous; it clears control and the activation and error
// stores and presets sizes and step size. Weights and biases are undefined until loaded.
module dense_layer_forward_backward_sgd_core import dlfb_pkg::*; #(
   parameter int MAX_INPUTS  = 16,
   parameter int MAX_OUTPUTS = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [LR_WIDTH-1:0]  csr_data
);

   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
   localparam int AW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   function automatic logic signed [31:0] sat_dw(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[31:0];
   endfunction

   // configuration
   logic [SIZE_WIDTH-1:0] inputs_ff, outputs_ff;
   logic [LR_WIDTH-1:0]   lr_ff;
   logic [SIZE_WIDTH-1:0] n_use, m_use;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inputs_ff  <= 7'd16;
         outputs_ff <= 7'd16;
         lr_ff      <= 16'd655;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUTS:  inputs_ff  <= csr_data[SIZE_WIDTH-1:0];
            CSR_OUTPUTS: outputs_ff <= csr_data[SIZE_WIDTH-1:0];
            CSR_LRATE:   lr_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp sizes between one and the built store depths
   always_comb begin
      n_use = inputs_ff;
      if (inputs_ff == '0) n_use = 7'd1;
      if (inputs_ff > SIZE_WIDTH'(MAX_INPUTS)) n_use = SIZE_WIDTH'(MAX_INPUTS);
      m_use = outputs_ff;
      if (outputs_ff == '0) m_use = 7'd1;
      if (outputs_ff > SIZE_WIDTH'(MAX_OUTPUTS)) m_use = SIZE_WIDTH'(MAX_OUTPUTS);
   end

   // request decode
   logic               accept;
   logic               row_ok, col_ok;
   logic signed [31:0] sval;
   logic [IW-1:0]      rowi;
   logic [OW-1:0]      coli;
   launch_type         launch;
   cmd_type            cmd;
   logic               rd_ok_ff;
   logic [5:0]         rd_col_ff;

   assign accept = start && !busy;
   assign row_ok = ({1'b0, req_item.row} < n_use);
   assign col_ok = ({1'b0, req_item.col} < m_use);
   assign sval   = sat_dw({{32{req_item.value[31]}}, req_item.value});
   assign rowi   = req_item.row[IW-1:0];
   assign coli   = req_item.col[OW-1:0];

   always_comb begin
      launch    = '0;
      launch.op = K_FWD;
      launch.ri = req_item.row;
      launch.ci = req_item.col;
      if (accept) begin
         case (req_item.req_type)
            REQ_FWD: begin
               launch.go = req_item.last;
               launch.op = K_FWD;
            end
            REQ_ERR: begin
               launch.go = req_item.last;
               launch.op = K_ERR;
            end
            REQ_READ_W: begin
               launch.go = 1'b1;
               launch.op = K_RDW;
            end
            REQ_READ_B: begin
               launch.go = 1'b1;
               launch.op = K_RDB;
            end
            default: ;
         endcase
      end
   end

   // hold read-back status for the result
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_col_ff <= req_item.col;
         rd_ok_ff  <= (req_item.req_type == REQ_READ_B) ? col_ok : (row_ok && col_ok);
      end
   end

   dlfb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .n_m1   (n_use - 1'b1),
      .m_m1   (m_use - 1'b1),
      .cmd    (cmd),
      .busy   (busy)
   );

   // activation and error stores
   logic signed [31:0] xs_ff [MAX_INPUTS];
   logic signed [31:0] es_ff [MAX_OUTPUTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_INPUTS; i++) xs_ff[i] <= '0;
         for (int j = 0; j < MAX_OUTPUTS; j++) es_ff[j] <= '0;
      end else if (accept) begin
         if (req_item.req_type == REQ_FWD && row_ok) xs_ff[rowi] <= sval;
         if (req_item.req_type == REQ_ERR && col_ok) es_ff[coli] <= sval;
      end
   end

   // memories
   logic          w_we, b_we;
   logic [AW-1:0] w_waddr, w_raddr;
   logic [OW-1:0] b_waddr;
   logic [31:0]   w_wdata, b_wdata, w_rdata, b_rdata;

   assign w_raddr = AW'(int'(cmd.ri[IW-1:0]) * MAX_OUTPUTS + int'(cmd.ci[OW-1:0]));

   dlfb_ram #(.DEPTH(WDEPTH), .WIDTH(32), .AW(AW)) u_wram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   dlfb_ram #(.DEPTH(MAX_OUTPUTS), .WIDTH(32), .AW(OW)) u_bram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (cmd.ci[OW-1:0]),
      .rdata (b_rdata)
   );

   // stage 1: operands beside the memory data, first multiply
   cmd_type            s1_ff, s2_ff, s3_ff;
   logic signed [31:0] x1_ff, e1_ff;
   logic signed [31:0] mul_a, mul_b, aux1;
   logic signed [63:0] prod_in, prod_ff;
   logic signed [31:0] aux2_ff, aux3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= cmd;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= xs_ff[cmd.ri[IW-1:0]];
      e1_ff <= es_ff[cmd.ci[OW-1:0]];
   end

   always_comb begin
      mul_a = x1_ff;
      mul_b = e1_ff;
      aux1  = w_rdata;
      case (s1_ff.kind)
         K_FWD: begin
            mul_b = w_rdata;
            aux1  = b_rdata;
         end
         K_ERR: begin
            mul_a = e1_ff;
            mul_b = w_rdata;
         end
         K_BUPD: begin
            mul_a = ONE_Q16;
            aux1  = b_rdata;
         end
         K_RDB: aux1 = b_rdata;
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      aux2_ff <= aux1;
   end

   // stage 2: accumulate, scale the update by the step size
   logic signed [47:0] delta;
   logic signed [63:0] delta64;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod2_in, prod2_ff;

   assign delta    = prod_ff[63:FRAC_BITS];
   assign delta64  = {{16{delta[47]}}, delta};
   assign acc_in   = (s2_ff.first ? 64'sd0 : acc_ff) + delta64;
   assign prod2_in = delta64 * $signed({48'd0, lr_ff});

   always_ff @(posedge clock) begin
      if (s2_ff.valid && (s2_ff.kind == K_FWD || s2_ff.kind == K_ERR)) begin
         acc_ff <= acc_in;
      end
      prod2_ff <= prod2_in;
      aux3_ff  <= aux2_ff;
   end

   // stage 3: saturate, write back updates, emit results
   logic signed [63:0] aux64, step, newv;
   logic               upd_w, upd_b;
   logic               rsp_valid_in, rsp_valid_ff;
   rsp_item_type       rsp_in, rsp_ff;

   assign aux64 = {{32{aux3_ff[31]}}, aux3_ff};
   assign step  = prod2_ff >>> FRAC_BITS;
   assign newv  = aux64 - step;
   assign upd_w = s3_ff.valid && (s3_ff.kind == K_UPD);
   assign upd_b = s3_ff.valid && (s3_ff.kind == K_BUPD);

   always_comb begin
      w_we    = upd_w;
      w_waddr = AW'(int'(s3_ff.ri[IW-1:0]) * MAX_OUTPUTS + int'(s3_ff.ci[OW-1:0]));
      w_wdata = sat_dw(newv);
      b_we    = upd_b;
      b_waddr = s3_ff.ci[OW-1:0];
      b_wdata = sat_dw(newv);
      if (accept && req_item.req_type == REQ_LOAD_W) begin
         w_we    = row_ok && col_ok;
         w_waddr = AW'(int'(rowi) * MAX_OUTPUTS + int'(coli));
         w_wdata = sval;
      end
      if (accept && req_item.req_type == REQ_LOAD_B) begin
         b_we    = col_ok;
         b_waddr = coli;
         b_wdata = sval;
      end
   end

   always_comb begin
      rsp_valid_in       = 1'b0;
      rsp_in.out_kind    = OUT_FWD;
      rsp_in.out_index   = s3_ff.ci;
      rsp_in.out_value   = sat_dw(acc_ff + aux64);
      rsp_in.out_last    = s3_ff.rend;
      if (s3_ff.valid) begin
         case (s3_ff.kind)
            K_FWD: rsp_valid_in = s3_ff.gend;
            K_ERR: begin
               rsp_valid_in     = s3_ff.gend;
               rsp_in.out_kind  = OUT_ERR;
               rsp_in.out_index = s3_ff.ri;
               rsp_in.out_value = sat_dw(acc_ff);
            end
            K_RDW, K_RDB: begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_kind  = OUT_READ;
               rsp_in.out_index = rd_col_ff;
               rsp_in.out_value = rd_ok_ff ? aux3_ff : 32'sd0;
               rsp_in.out_last  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/dlfb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module dlfb_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dlfb_seq.sv =====
// Sequencer that walks the weight memory for runs, updates and reads.
module dlfb_seq import dlfb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  launch_type            launch,
   input  logic [SIZE_WIDTH-1:0] n_m1,
   input  logic [SIZE_WIDTH-1:0] m_m1,
   output cmd_type               cmd,
   output logic                  busy
);

   state_type            state_ff, state_in;
   logic [IDX_WIDTH-1:0] ri_ff, ri_in;
   logic [IDX_WIDTH-1:0] ci_ff, ci_in;
   kind_type             rdkind_ff, rdkind_in;
   logic [1:0]           drain_ff, drain_in;
   logic                 ilast;
   logic                 jlast;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ri_ff     <= '0;
         ci_ff     <= '0;
         rdkind_ff <= K_RDW;
         drain_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ri_ff     <= ri_in;
         ci_ff     <= ci_in;
         rdkind_ff <= rdkind_in;
         drain_ff  <= drain_in;
      end
   end

   assign ilast = ({1'b0, ri_ff} == n_m1);
   assign jlast = ({1'b0, ci_ff} == m_m1);

   // advance counters and issue one access per cycle outside idle and drain
   always_comb begin
      state_in  = state_ff;
      ri_in     = ri_ff;
      ci_in     = ci_ff;
      rdkind_in = rdkind_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.kind  = K_FWD;
      cmd.ri    = ri_ff;
      cmd.ci    = ci_ff;
      busy      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (launch.go) begin
               ri_in = '0;
               ci_in = '0;
               unique case (launch.op)
                  K_FWD: state_in = ST_FWD;
                  K_ERR: state_in = ST_ERR;
                  default: begin
                     state_in  = ST_READ;
                     rdkind_in = launch.op;
                     ri_in     = launch.ri;
                     ci_in     = launch.ci;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.valid = 1'b1;
            cmd.kind  = rdkind_ff;
            state_in  = ST_DRAIN;
            drain_in  = 2'd3;
         end
         ST_FWD: begin
            cmd.valid = 1'b1;
            cmd.kind  = K_FWD;
            cmd.first = (ri_ff == '0);
            cmd.gend  = ilast;
            cmd.rend  = ilast && jlast;
            if (ilast) begin
               ri_in = '0;
               if (jlast) begin
                  state_in = ST_DRAIN;
                  drain_in = 2'd3;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end else begin
               ri_in = ri_ff + 1'b1;
            end
         end
         ST_ERR: begin
            cmd.valid = 1'b1;
            cmd.kind  = K_ERR;
            cmd.first = (ci_ff == '0);
            cmd.gend  = jlast;
            cmd.rend  = jlast && ilast;
            if (jlast) begin
               ci_in = '0;
               if (ilast) begin
                  ri_in    = '0;
                  state_in = ST_UPD;
               end else begin
                  ri_in = ri_ff + 1'b1;
               end
            end else begin
               ci_in = ci_ff + 1'b1;
            end
         end
         ST_UPD: begin
            cmd.valid = 1'b1;
            cmd.kind  = K_UPD;
            if (jlast) begin
               ci_in = '0;
               if (ilast) begin
                  ri_in    = '0;
                  state_in = ST_BUPD;
               end else begin
                  ri_in = ri_ff + 1'b1;
               end
            end else begin
               ci_in = ci_ff + 1'b1;
            end
         end
         ST_BUPD: begin
            cmd.valid = 1'b1;
            cmd.kind  = K_BUPD;
            if (jlast) begin
               state_in = ST_DRAIN;
               drain_in = 2'd3;
            end else begin
               ci_in = ci_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/dlfb_checker.sv =====
// Port-level checks for the dense layer core and their binding.
`include "dense_layer_forward_backward_sgd_core_defines.svh"

module dlfb_checker import dlfb_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input req_item_type        req_item,
   input logic                rsp_valid,
   input rsp_item_type        rsp_item,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [1:0]          csr_index,
   input logic [LR_WIDTH-1:0] csr_data
);

   logic take_read, take_load;

   // decode accepted reads and loads
   assign take_read = start && !busy &&
                      (req_item.req_type == REQ_READ_W || req_item.req_type == REQ_READ_B);
   assign take_load = start && !busy &&
                      (req_item.req_type == REQ_LOAD_W || req_item.req_type == REQ_LOAD_B);

   // results only come while the core reports busy
   `DLFB_ASSERT_IMPL(a_rsp_in_busy, rsp_valid, busy)
   // a read always closes its own run
   `DLFB_ASSERT_IMPL(a_read_last, rsp_valid && rsp_item.out_kind == OUT_READ, rsp_item.out_last)
   // an accepted read keeps the core busy
   `DLFB_ASSERT_NEXT(a_read_busy, take_read, busy)
   // loads finish in the accepting cycle
   `DLFB_ASSERT_NEXT(a_load_free, take_load, !busy)

endmodule

bind dense_layer_forward_backward_sgd_core dlfb_checker u_dlfb_checker (.*);

// ===== verif/dense_layer_forward_backward_sgd_core_tb.sv =====
// Testbench for the dense layer core: directed and random items checked against a predictor.
module dense_layer_forward_backward_sgd_core_tb;
   import dlfb_pkg::*;

   localparam int MAXI = 16;
   localparam int MAXO = 16;
   localparam longint CYCLE_LIMIT = 3000000;

   // layer predictor and queue of expected results
   class layer_scoreboard;
      int unsigned n_cfg, m_cfg, lr_cfg;
      longint wgt [MAXI*MAXO];
      longint bia [MAXO];
      longint act [MAXI];
      longint err [MAXO];
      rsp_item_type pending_q[$];
      int errors;

      function new();
         n_cfg = 16; m_cfg = 16; lr_cfg = 655; errors = 0;
         foreach (wgt[k]) wgt[k] = 0;
         foreach (bia[k]) begin bia[k] = 0; err[k] = 0; end
         foreach (act[k]) act[k] = 0;
      endfunction

      function longint fshr(longint v);
         return v >>> FRAC_BITS;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void push(logic [1:0] kind, int idx, longint val, bit lst);
         rsp_item_type r;
         r.out_kind = kind; r.out_index = idx[5:0];
         r.out_value = val[31:0]; r.out_last = lst;
         pending_q.push_back(r);
      endfunction

      function void write_csr(logic [1:0] idx, logic [15:0] data);
         if (idx == CSR_INPUTS) n_cfg = data[6:0];
         else if (idx == CSR_OUTPUTS) m_cfg = data[6:0];
         else if (idx == CSR_LRATE) lr_cfg = data;
      endfunction

      // note an accepted item and queue its results
      function void note_item(req_item_type it);
         int n, m;
         bit rok, cok;
         longint v, acc, dlt;
         n = (n_cfg < 1) ? 1 : (n_cfg > MAXI) ? MAXI : n_cfg;
         m = (m_cfg < 1) ? 1 : (m_cfg > MAXO) ? MAXO : m_cfg;
         rok = it.row < n;
         cok = it.col < m;
         v = longint'(it.value);
         case (it.req_type)
            REQ_LOAD_W: if (rok && cok) wgt[it.row*MAXO+it.col] = v;
            REQ_LOAD_B: if (cok) bia[it.col] = v;
            REQ_READ_W: push(OUT_READ, it.col,
                             (rok && cok) ? wgt[it.row*MAXO+it.col] : 0, 1);
            REQ_READ_B: push(OUT_READ, it.col, cok ? bia[it.col] : 0, 1);
            REQ_FWD: begin
               if (rok) act[it.row] = v;
               if (it.last) begin
                  for (int j = 0; j < m; j++) begin
                     acc = 0;
                     for (int i = 0; i < n; i++) acc += fshr(act[i] * wgt[i*MAXO+j]);
                     push(OUT_FWD, j, sat32(acc + bia[j]), j + 1 == m);
                  end
               end
            end
            REQ_ERR: begin
               if (cok) err[it.col] = v;
               if (it.last) begin
                  for (int i = 0; i < n; i++) begin
                     acc = 0;
                     for (int j = 0; j < m; j++) acc += fshr(err[j] * wgt[i*MAXO+j]);
                     push(OUT_ERR, i, sat32(acc), i + 1 == n);
                  end
                  for (int i = 0; i < n; i++)
                     for (int j = 0; j < m; j++) begin
                        dlt = fshr(act[i] * err[j]);
                        wgt[i*MAXO+j] = sat32(wgt[i*MAXO+j] - fshr(dlt * lr_cfg));
                     end
                  for (int j = 0; j < m; j++)
                     bia[j] = sat32(bia[j] - fshr(err[j] * lr_cfg));
               end
            end
            default: ;
         endcase
      endfunction

      // compare a result with the oldest expectation
      function void check_result(rsp_item_type got, longint t);
         rsp_item_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", t, got);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.out_kind !== want.out_kind) begin
            $display("%0t: out_kind expected %0d actual %0d", t, want.out_kind, got.out_kind);
            errors++;
         end
         if (got.out_index !== want.out_index) begin
            $display("%0t: out_index expected %0d actual %0d", t, want.out_index,
                     got.out_index);
            errors++;
         end
         if (got.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h actual %h", t, want.out_value,
                     got.out_value);
            errors++;
         end
         if (got.out_last !== want.out_last) begin
            $display("%0t: out_last expected %0d actual %0d", t, want.out_last, got.out_last);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic [1:0] csr_index;
   logic [15:0] csr_data;
   layer_scoreboard sb;
   longint cycle_count = 0;
   int gap_pct;
   int cur_n, cur_m;
   bit [MAXI*MAXO-1:0] w_known;
   bit [MAXO-1:0] b_known;

   dense_layer_forward_backward_sgd_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // check results and watch the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) sb.check_result(rsp_item, $time);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // send one item, with a random idle gap first; start stays high into the next item
   task automatic send_item(req_item_type it);
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sb.note_item(it);
      // track which stored entries hold defined values
      if (it.req_type == REQ_LOAD_W && it.row < cur_n && it.col < cur_m)
         w_known[it.row*MAXO+it.col] = 1;
      if (it.req_type == REQ_LOAD_B && it.col < cur_m) b_known[it.col] = 1;
   endtask

   // drop start and wait for every expected result
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_csr(idx, data);
   endtask

   // set sizes, then load every bias in use and every undefined weight in use, and reload some defined ones
   task automatic set_layer(int n, int m, logic [15:0] lr, bit extreme);
      req_item_type it;
      drain();
      write_reg(CSR_INPUTS, n[15:0]);
      write_reg(CSR_OUTPUTS, m[15:0]);
      write_reg(CSR_LRATE, lr);
      csr_valid <= 1'b0;
      cur_n = (n < 1) ? 1 : (n > MAXI) ? MAXI : n;
      cur_m = (m < 1) ? 1 : (m > MAXO) ? MAXO : m;
      for (int i = 0; i < cur_n; i++)
         for (int j = 0; j < cur_m; j++) begin
            if (w_known[i*MAXO+j] && $urandom_range(3) != 0) continue;
            it = '0;
            it.req_type = REQ_LOAD_W; it.row = 6'(i); it.col = 6'(j);
            it.value = extreme ? $urandom : $signed($urandom_range(262143)) - 131072;
            it.last = 1'($urandom_range(1));
            send_item(it);
         end
      for (int j = 0; j < cur_m; j++) begin
         it = '0;
         it.req_type = REQ_LOAD_B; it.col = 6'(j);
         it.value = extreme ? $urandom : $signed($urandom_range(262143)) - 131072;
         send_item(it);
      end
   endtask

   function automatic req_item_type rand_item(bit wide);
      req_item_type it;
      int r;
      it = '0;
      r = $urandom_range(99);
      it.row = 6'($urandom_range(cur_n - 1));
      it.col = 6'($urandom_range(cur_m - 1));
      it.value = wide ? $urandom : $signed($urandom_range(262143)) - 131072;
      it.last = ($urandom_range(5) == 0);
      if (r < 35) it.req_type = REQ_FWD;
      else if (r < 60) it.req_type = REQ_ERR;
      else if (r < 72) it.req_type = REQ_READ_W;
      else if (r < 80) it.req_type = REQ_READ_B;
      else if (r < 88) it.req_type = REQ_LOAD_W;
      else if (r < 93) it.req_type = REQ_LOAD_B;
      else if (r < 96) it.req_type = 3'($urandom_range(6, 7));
      else begin
         // out of range index, only where the entry read is never undefined
         it.req_type = REQ_FWD;
         it.row = 6'($urandom_range(63));
         it.col = 6'($urandom_range(63));
         if ($urandom_range(1)) it.req_type = REQ_ERR;
      end
      return it;
   endfunction

   initial begin
      req_item_type it;
      sb = new();
      reset = 1'b1; start = 1'b0; req_item = '0;
      csr_valid = 1'b0; csr_index = CSR_INPUTS; csr_data = '0;
      gap_pct = 16; cur_n = 16; cur_m = 16; w_known = '0; b_known = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small layer with extreme values and all codes
      set_layer(2, 3, 16'hFFFF, 1);
      for (int k = 0; k < 2; k++) begin
         it = '0; it.req_type = REQ_FWD; it.row = 6'(k); it.last = (k == 1);
         it.value = k ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         send_item(it);
      end
      it = '0; it.req_type = REQ_READ_W; it.row = 1; it.col = 2; it.last = 1; send_item(it);
      it = '0; it.req_type = REQ_READ_B; it.col = 0; send_item(it);
      it = '0; it.req_type = REQ_READ_W; it.row = 63; it.col = 63; send_item(it);
      it = '0; it.req_type = REQ_READ_B; it.col = 40; send_item(it);
      it = '0; it.req_type = REQ_LOAD_W; it.row = 50; it.col = 1; it.value = 5; send_item(it);
      it = '0; it.req_type = REQ_LOAD_B; it.col = 33; it.value = 7; send_item(it);
      it = '0; it.req_type = 3'd6; it.last = 1; send_item(it);
      it = '0; it.req_type = 3'd7; it.value = '1; send_item(it);
      for (int k = 0; k < 3; k++) begin
         it = '0; it.req_type = REQ_ERR; it.col = 6'(k); it.last = (k == 2);
         it.value = (k == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         send_item(it);
      end
      it = '0; it.req_type = REQ_ERR; it.col = 63; it.row = 63; it.value = ONE_Q16;
      it.last = 1; send_item(it);
      it = '0; it.req_type = REQ_FWD; it.row = 45; it.value = ONE_Q16; it.last = 1;
      send_item(it);

      // random phases over several layer settings, sizes clamped at the ends
      for (int ph = 0; ph < 6; ph++) begin
         gap_pct = (ph == 1) ? 0 : 16;
         case (ph)
            0: set_layer(0, 0, 16'd0, 0);
            1: set_layer(4, 4, 16'd655, 0);
            2: set_layer(100, 1, 16'd32768, 1);
            3: set_layer(1, 127, 16'hFFFF, 0);
            4: set_layer($urandom_range(1, 8), $urandom_range(1, 8), 16'($urandom), 0);
            default: set_layer($urandom_range(1, 6), $urandom_range(1, 6), 16'($urandom), 1);
         endcase
         for (int k = 0; k < 20; k++) send_item(rand_item(ph == 2 || ph == 5));
         // hold off until all results are in
         if (ph == 3) drain();
      end

      drain();
      if (sb.errors == 0 && sb.pending_q.size() == 0) $display("PASS");
      else begin
         if (sb.pending_q.size() != 0)
            $display("%0t: %0d results expected, none arrived", $time,
                     sb.pending_q.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dlfb_pkg.sv
rtl/dlfb_ram.sv
rtl/dlfb_seq.sv
rtl/dense_layer_forward_backward_sgd_core.sv
rtl/dlfb_checker.sv
verif/dense_layer_forward_backward_sgd_core_tb.sv
